FILE: rtl/svrs_pkg.sv
// Shared types, constants and the ramp move function of the stereo volume ramp sequencer.
package svrs_pkg;

    localparam int unsigned RoundW = 4;
    localparam logic [RoundW-1:0] LastRound = 4'd8;

    localparam logic [7:0] BaseStepRst = 8'd25;
    localparam logic [6:0] LeftAddrRst = 7'd10;
    localparam logic [6:0] RightAddrRst = 7'd11;
    localparam logic [7:0] VolumeRst = 8'd255;

    localparam logic [8:0] MagCap = 9'h100;

    localparam logic [1:0] RegBaseStep = 2'd0;
    localparam logic [1:0] RegLeftAddr = 2'd1;
    localparam logic [1:0] RegRightAddr = 2'd2;

    localparam logic ChanLeft = 1'b0;
    localparam logic ChanRight = 1'b1;

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_LEFT  = 3'b010,
        S_RIGHT = 3'b100
    } state_t;

    typedef struct packed
    {
        logic load;
        logic step_left;
        logic step_right;
        logic advance;
        logic left_last;
        logic right_last;
    } cmd_t;

    typedef struct packed
    {
        logic l_eq;
        logic r_eq;
        logic l_settle;
        logic r_settle;
        logic last_round;
        logic out_free;
    } sts_t;

    // new attenuation after one move; mag saturates at 256
    function automatic logic [7:0] ramp_move(
        input logic [7:0] cur,
        input logic [7:0] tgt,
        input logic [8:0] mag,
        input logic       neg
    );
        logic signed [8:0] diff;
        logic [7:0]        absd;
        logic [7:0]        step8;
        logic [7:0]        res;
        diff = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        absd = diff[8] ? 8'(-diff) : diff[7:0];
        step8 = neg ? 8'(-mag[7:0]) : mag[7:0];
        if ({1'b0, absd} <= mag)
        begin
            res = tgt;
        end
        else if ({2'b00, absd} < {mag, 1'b0})
        begin
            res = cur + diff[8:1];
        end
        else
        begin
            res = cur + step8;
        end
        return res;
    endfunction

endpackage

FILE: rtl/svrs_ctrl.sv
// Controller state machine sequencing the rounds of left and right writes.
module svrs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  svrs_pkg::sts_t      sts,
    output svrs_pkg::cmd_t      cmd
);
    import svrs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done;

    assign done = (sts.l_eq && sts.r_settle) || sts.last_round;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.left_last = sts.r_eq && (sts.l_settle || sts.last_round);
        cmd.right_last = done;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                if (sts.l_eq)
                begin
                    state_next = sts.r_eq ? S_IDLE : S_RIGHT;
                end
                else if (sts.out_free)
                begin
                    cmd.step_left = 1'b1;
                    state_next = S_RIGHT;
                end
            end
            S_RIGHT:
            begin
                if (sts.r_eq || sts.out_free)
                begin
                    cmd.step_right = !sts.r_eq;
                    cmd.advance = 1'b1;
                    state_next = done ? S_IDLE : S_LEFT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/svrs_dp.sv
// Datapath: volume state, working attenuations, step, round count and output register.
module svrs_dp
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      target_left,
    input  logic [7:0]      target_right,
    input  logic [7:0]      base_step,
    input  logic [6:0]      left_reg_addr,
    input  logic [6:0]      right_reg_addr,
    input  svrs_pkg::cmd_t  cmd,
    output svrs_pkg::sts_t  sts,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);
    import svrs_pkg::*;

    logic [7:0]        vol_l_reg;
    logic [7:0]        vol_r_reg;
    logic [7:0]        cur_l_reg;
    logic [7:0]        cur_r_reg;
    logic [7:0]        tgt_l_reg;
    logic [7:0]        tgt_r_reg;
    logic [8:0]        mag_reg;
    logic              neg_reg;
    logic [RoundW-1:0] round_reg;
    logic              valid_reg;
    logic [15:0]       frame_reg;
    logic              chan_reg;
    logic              last_reg;

    logic [7:0] l_new;
    logic [7:0] r_new;
    logic [7:0] ld_tgt_l;
    logic [7:0] ld_tgt_r;
    logic [7:0] ld_cur_l;
    logic [7:0] ld_cur_r;
    logic [8:0] mag_next;

    assign l_new = ramp_move(cur_l_reg, tgt_l_reg, mag_reg, neg_reg);
    assign r_new = ramp_move(cur_r_reg, tgt_r_reg, mag_reg, neg_reg);

    assign ld_tgt_l = ~target_left;
    assign ld_tgt_r = ~target_right;
    assign ld_cur_l = ~vol_l_reg;
    assign ld_cur_r = ~vol_r_reg;

    assign mag_next = (mag_reg[8] || mag_reg[7]) ? MagCap : {mag_reg[7:0], 1'b0};

    assign sts.l_eq = (cur_l_reg == tgt_l_reg);
    assign sts.r_eq = (cur_r_reg == tgt_r_reg);
    assign sts.l_settle = (l_new == tgt_l_reg);
    assign sts.r_settle = (r_new == tgt_r_reg);
    assign sts.last_round = (round_reg == LastRound);
    assign sts.out_free = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata = frame_reg;
    assign m_tuser = chan_reg;
    assign m_tlast = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_l_reg <= VolumeRst;
            vol_r_reg <= VolumeRst;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                vol_l_reg <= target_left;
                vol_r_reg <= target_right;
            end
            if (cmd.step_left || cmd.step_right)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tgt_l_reg <= ld_tgt_l;
            tgt_r_reg <= ld_tgt_r;
            cur_l_reg <= ld_cur_l;
            cur_r_reg <= ld_cur_r;
            mag_reg <= (base_step == 8'd0) ? 9'd1 : {1'b0, base_step};
            neg_reg <= (ld_tgt_l < ld_cur_l) || (ld_tgt_r < ld_cur_r);
            round_reg <= '0;
        end
        else
        begin
            if (cmd.step_left)
            begin
                cur_l_reg <= l_new;
                frame_reg <= {left_reg_addr, 1'b1, ~l_new};
                chan_reg <= ChanLeft;
                last_reg <= cmd.left_last;
            end
            else if (cmd.step_right)
            begin
                cur_r_reg <= r_new;
                frame_reg <= {right_reg_addr, 1'b1, ~r_new};
                chan_reg <= ChanRight;
                last_reg <= cmd.right_last;
            end
            if (cmd.advance)
            begin
                mag_reg <= mag_next;
                round_reg <= round_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/stereo_volume_ramp_sequencer_core.sv
// Each accepted transfer carries new left and right volume targets. The block
// ramps the stored volumes toward them in attenuation space over up to nine
// rounds of doubling step size, sending one 16-bit codec write word per
// unfinished channel per round (left before right), tlast on the final word.
// Targets equal to the stored volumes produce no output. Each round has a left
// slot and a right slot in the controller, after the accept in idle; a slot
// waits while m_tready stalls the output. Each word shows on m_tvalid in the
// cycle after its slot; a new transfer is taken only once the controller is
// back in idle.
module stereo_volume_ramp_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // target_left [7:0], target_right [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame [15:0]
    output logic        m_tuser,   // channel [0]
    output logic        m_tlast
);
    import svrs_pkg::*;

    logic [7:0] base_step_reg;
    logic [6:0] left_addr_reg;
    logic [6:0] right_addr_reg;
    logic       wr_en;
    cmd_t       cmd;
    sts_t       sts;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg <= BaseStepRst;
            left_addr_reg <= LeftAddrRst;
            right_addr_reg <= RightAddrRst;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                RegBaseStep:  base_step_reg <= pwdata[7:0];
                RegLeftAddr:  left_addr_reg <= pwdata[6:0];
                RegRightAddr: right_addr_reg <= pwdata[6:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            RegBaseStep:  prdata = {24'd0, base_step_reg};
            RegLeftAddr:  prdata = {25'd0, left_addr_reg};
            RegRightAddr: prdata = {25'd0, right_addr_reg};
            default:      prdata = '0;
        endcase
    end

    svrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svrs_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .target_left    (s_tdata[7:0]),
        .target_right   (s_tdata[15:8]),
        .base_step      (base_step_reg),
        .left_reg_addr  (left_addr_reg),
        .right_reg_addr (right_addr_reg),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

FILE: dv/stereo_volume_ramp_sequencer_core_tb.sv
// Self-checking testbench for the stereo volume ramp sequencer core.
module stereo_volume_ramp_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svrs_pkg::*;

    localparam int SettleCycles = 40;
    localparam int CycleLimit = 500000;

    typedef struct packed
    {
        logic        chan;
        logic [15:0] frame;
        logic        last;
    } codec_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic [15:0]  target_q[$];
    codec_word_t  frame_q[$];

    logic [7:0] cfg_base;
    logic [6:0] cfg_laddr;
    logic [6:0] cfg_raddr;
    logic [7:0] vol_left;
    logic [7:0] vol_right;

    logic [7:0] gen_left;
    logic [7:0] gen_right;

    bit in_taken;
    bit idle_on;
    int in_gap;
    int out_gap;
    int errors;
    int cycles;

    stereo_volume_ramp_sequencer_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] next_atten(int step, int cur, int goal);
        int diff;
        int dmag;
        int smag;
        int nxt;
        diff = goal - cur;
        dmag = (diff < 0) ? -diff : diff;
        smag = (step < 0) ? -step : step;
        if (dmag <= smag)
        begin
            nxt = goal;
        end
        else if (dmag < 2 * smag)
        begin
            nxt = cur + (diff >>> 1);
        end
        else
        begin
            nxt = cur + step;
        end
        return nxt[7:0];
    endfunction

    function automatic void plan_ramp(logic [7:0] tl, logic [7:0] tr);
        int          goal_l;
        int          goal_r;
        int          att_l;
        int          att_r;
        int          step;
        bit          have;
        codec_word_t held;
        codec_word_t w;
        goal_l = 255 - int'(tl);
        goal_r = 255 - int'(tr);
        att_l = 255 - int'(vol_left);
        att_r = 255 - int'(vol_right);
        step = (cfg_base == 8'd0) ? 1 : int'(cfg_base);
        have = 1'b0;
        if (goal_l < att_l || goal_r < att_r)
        begin
            step = -step;
        end
        for (int r = 0; r < 9; r++)
        begin
            if (att_l == goal_l && att_r == goal_r)
            begin
                break;
            end
            if (att_l != goal_l)
            begin
                att_l = int'(next_atten(step, att_l, goal_l));
                w.chan = ChanLeft;
                w.frame = {cfg_laddr, 1'b1, 8'(255 - att_l)};
                w.last = 1'b0;
                if (have)
                begin
                    frame_q.push_back(held);
                end
                held = w;
                have = 1'b1;
            end
            if (att_r != goal_r)
            begin
                att_r = int'(next_atten(step, att_r, goal_r));
                w.chan = ChanRight;
                w.frame = {cfg_raddr, 1'b1, 8'(255 - att_r)};
                w.last = 1'b0;
                if (have)
                begin
                    frame_q.push_back(held);
                end
                held = w;
                have = 1'b1;
            end
            step = step * 2;
        end
        if (have)
        begin
            held.last = 1'b1;
            frame_q.push_back(held);
        end
        vol_left = tl;
        vol_right = tr;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        codec_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected frame %h", m_tdata));
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (m_tuser !== want.chan)
                    begin
                        report_mismatch($sformatf("channel %b, want %b", m_tuser, want.chan));
                    end
                    if (m_tdata !== want.frame)
                    begin
                        report_mismatch($sformatf("frame %h, want %h", m_tdata, want.frame));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                plan_ramp(s_tdata[7:0], s_tdata[15:8]);
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && !in_taken))
            begin
                in_taken = 1'b0;
                if (in_gap == 0 && idle_on && $urandom_range(0, 3) == 0)
                begin
                    in_gap = $urandom_range(1, 8);
                end
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (target_q.size() > 0)
                begin
                    s_tdata <= target_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_gap = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            RegBaseStep:  cfg_base = val[7:0];
            RegLeftAddr:  cfg_laddr = val[6:0];
            RegRightAddr: cfg_raddr = val[6:0];
            default:      ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] b, input logic [6:0] la, input logic [6:0] ra);
        reg_write(RegBaseStep, {24'd0, b});
        reg_write(RegLeftAddr, {25'd0, la});
        reg_write(RegRightAddr, {25'd0, ra});
    endtask

    task automatic queue_targets(input logic [7:0] tl, input logic [7:0] tr);
        target_q.push_back({tr, tl});
        gen_left = tl;
        gen_right = tr;
    endtask

    // hold until every transfer is taken and every frame has come out
    task automatic drain();
        while (target_q.size() > 0 || s_tvalid || frame_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: queue_targets(gen_left, gen_right);
                1: queue_targets(gen_left, 8'($urandom));
                2: queue_targets(8'($urandom), gen_right);
                3: queue_targets($urandom_range(0, 1) ? 8'd255 : 8'd0,
                                 $urandom_range(0, 1) ? 8'd255 : 8'd0);
                default: queue_targets(8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    function automatic logic [7:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        in_taken = 1'b0;
        idle_on = 1'b1;
        in_gap = 0;
        out_gap = 0;
        errors = 0;
        cycles = 0;
        cfg_base = BaseStepRst;
        cfg_laddr = LeftAddrRst;
        cfg_raddr = RightAddrRst;
        vol_left = VolumeRst;
        vol_right = VolumeRst;
        gen_left = VolumeRst;
        gen_right = VolumeRst;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset settings: no change, full swings, opposite directions
        queue_targets(8'd255, 8'd255);
        queue_targets(8'd0, 8'd0);
        queue_targets(8'd255, 8'd255);
        queue_targets(8'd0, 8'd255);
        queue_targets(8'd255, 8'd0);
        queue_targets(8'd128, 8'd64);
        queue_targets(8'd64, 8'd128);
        queue_targets(8'd37, 8'd200);
        queue_targets(8'd37, 8'd200);
        drain();

        set_config(8'd255, 7'd0, 7'd127);
        queue_targets(8'd0, 8'd0);
        queue_targets(8'd255, 8'd255);
        queue_targets(8'd1, 8'd254);
        queue_targets(8'd254, 8'd1);
        queue_targets(8'd100, 8'd100);
        drain();

        // zero step behaves as a step of one
        set_config(8'd0, 7'd127, 7'd0);
        queue_targets(8'd0, 8'd255);
        queue_targets(8'd255, 8'd0);
        queue_targets(8'd128, 8'd128);
        drain();

        set_config(8'd1, 7'h55, 7'h2a);
        queue_targets(8'd0, 8'd0);
        queue_targets(8'd170, 8'd85);
        queue_targets(8'd85, 8'd170);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
            begin
                idle_on = 1'b0;
            end
            set_config(pick_step(), 7'($urandom), 7'($urandom));
            random_phase(78);
            drain();
        end

        if (frame_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d frames never arrived", frame_q.size()));
        end
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/svrs_pkg.sv
rtl/svrs_ctrl.sv
rtl/svrs_dp.sv
rtl/stereo_volume_ramp_sequencer_core.sv
dv/stereo_volume_ramp_sequencer_core_tb.sv
